// ===== rtl/bptc_pkg.sv =====
`default_nettype none
package bptc_pkg;

    // divider width, one quotient bit per stage
    localparam int DIV_W = 32;

    // register stages between the two dividers
    localparam int COEF_ST = 7;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_AC123 = 3'd0,
        REG_CAL_AC456 = 3'd1,
        REG_CAL_B12   = 3'd2,
        REG_CAL_MCMD  = 3'd3,
        REG_OSS       = 3'd4
    } reg_idx_t;

    localparam logic [1:0] OSS_RESET = 2'd3;

    // compensation constants
    localparam logic signed [31:0] C_B6_OFFSET = 32'sd4000;
    localparam logic signed [31:0] C_X3_OFFSET = 32'sd32768;
    localparam logic [15:0]        C_B7_SCALE  = 16'd50000;
    localparam logic signed [15:0] C_P_K1      = 16'sd3038;
    localparam logic signed [15:0] C_P_K2      = -16'sd7357;
    localparam logic signed [31:0] C_P_K3      = 32'sd3791;

    // unpacked calibration words
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } cal_t;

    // per item values that ride along the pipeline
    typedef struct packed {
        logic signed [31:0] x1;
        logic [23:0]        up;
        logic signed [15:0] t;
        logic               neg;
        logic               dbl;
        logic               fault;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/bptc_div.sv =====
`default_nettype none
module bptc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [bptc_pkg::DIV_W-1:0] num,
    input  wire logic [bptc_pkg::DIV_W-1:0] den,
    input  wire bptc_pkg::side_t           in_side,
    output logic                           out_valid,
    output logic [bptc_pkg::DIV_W-1:0]     quo,
    output bptc_pkg::side_t                out_side
);
    import bptc_pkg::*;

    logic [DIV_W-1:0] rem_reg  [DIV_W];
    logic [DIV_W-1:0] nq_reg   [DIV_W];
    logic [DIV_W-1:0] den_reg  [DIV_W];
    side_t            side_reg [DIV_W];
    logic [DIV_W-1:0] v_reg;

    logic [DIV_W-1:0] rem_next [DIV_W];
    logic [DIV_W-1:0] nq_next  [DIV_W];

    // one restoring step per stage, stage input from previous stage or port
    always_comb
    begin
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] nq_in;
        logic [DIV_W-1:0] den_in;
        logic [DIV_W:0]   trial;
        for (int k = 0; k < DIV_W; k++)
        begin
            if (k == 0)
            begin
                rem_in = '0;
                nq_in  = num;
                den_in = den;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                nq_in  = nq_reg[k-1];
                den_in = den_reg[k-1];
            end
            trial = {rem_in, nq_in[DIV_W-1]};
            if (trial >= {1'b0, den_in})
            begin
                rem_next[k] = DIV_W'(trial - {1'b0, den_in});
                nq_next[k]  = {nq_in[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DIV_W-1:0];
                nq_next[k]  = {nq_in[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den;
            side_reg[0] <= in_side;
            for (int k = 1; k < DIV_W; k++)
            begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < DIV_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
            end
        end
    end

    assign out_valid = v_reg[DIV_W-1];
    assign quo       = nq_reg[DIV_W-1];
    assign out_side  = side_reg[DIV_W-1];

endmodule
`default_nettype wire

// ===== rtl/bptc_coef.sv =====
`default_nettype none
module bptc_coef (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire bptc_pkg::cal_t             cal,
    input  wire logic                       in_valid,
    input  wire logic [bptc_pkg::DIV_W-1:0] in_q,
    input  wire bptc_pkg::side_t            in_side,
    output logic                            out_valid,
    output logic [bptc_pkg::DIV_W-1:0]      out_num,
    output logic [bptc_pkg::DIV_W-1:0]      out_den,
    output bptc_pkg::side_t                 out_side
);
    import bptc_pkg::*;

    logic [COEF_ST-1:0] v_reg;
    side_t              sd_reg [COEF_ST];
    side_t              sd2_next;
    logic signed [31:0] x2_reg, b5_reg, b6_reg, sq_reg, x2a_reg, x1c_reg;
    logic signed [31:0] x2a_d_reg, x1c_d_reg;
    logic signed [31:0] x1b_reg, x2c_reg, b3_reg, u_reg;
    logic [31:0]        b4_reg, b7_reg;

    logic signed [31:0] x2_next, b5_next, b6_next, sq_next, x2a_next, x1c_next;
    logic signed [31:0] x1b_next, x2c_next, b3_next, u_next;
    logic [31:0]        b4_next, b7_next;
    logic signed [31:0] tr_b5, b3_pre, b3_sh, x3, x3c;
    logic signed [27:0] t_wide;
    logic signed [15:0] t_next;
    logic signed [63:0] pr_sq;
    logic signed [47:0] pr_ac2, pr_ac3, pr_b2, pr_b1;
    logic [47:0]        pr_b4, pr_b7;
    logic [15:0]        b7_scale;

    // stage 1: apply quotient sign
    assign x2_next = in_side.neg ? $signed(~in_q + 32'd1) : $signed(in_q);

    // stage 2: b5
    assign b5_next = sd_reg[0].x1 + x2_reg;

    // stage 3: saturated temperature and b6
    always_comb
    begin
        tr_b5  = (b5_reg + 32'sd8) >>> 4;
        t_wide = tr_b5[27:0];
        if (t_wide > 28'sd32767)
            t_next = 16'sd32767;
        else if (t_wide < -28'sd32768)
            t_next = -16'sd32768;
        else
            t_next = t_wide[15:0];
        b6_next    = b5_reg - C_B6_OFFSET;
        sd2_next   = sd_reg[1];
        sd2_next.t = t_next;
    end

    // stage 4: products of b6
    always_comb
    begin
        pr_sq    = b6_reg * b6_reg;
        pr_ac2   = cal.ac2 * b6_reg;
        pr_ac3   = cal.ac3 * b6_reg;
        sq_next  = $signed(pr_sq[31:0]) >>> 12;
        x2a_next = $signed(pr_ac2[31:0]) >>> 11;
        x1c_next = $signed(pr_ac3[31:0]) >>> 13;
    end

    // stage 5: products of the squared term
    always_comb
    begin
        pr_b2    = cal.b2 * sq_reg;
        pr_b1    = cal.b1 * sq_reg;
        x1b_next = $signed(pr_b2[31:0]) >>> 11;
        x2c_next = $signed(pr_b1[31:0]) >>> 16;
    end

    // stage 6: b3 and the b4 operand
    always_comb
    begin
        x3      = x1b_reg + x2a_d_reg;
        b3_pre  = $signed({{14{cal.ac1[15]}}, cal.ac1, 2'b00}) + x3;
        b3_sh   = $signed(b3_pre << cal.oss);
        b3_next = (b3_sh + 32'sd2) >>> 2;
        x3c     = (x1c_d_reg + x2c_reg + 32'sd2) >>> 2;
        u_next  = x3c + C_X3_OFFSET;
    end

    // stage 7: b4 and b7, unsigned
    always_comb
    begin
        b7_scale = C_B7_SCALE >> cal.oss;
        pr_b4    = cal.ac4 * $unsigned(u_reg);
        b4_next  = pr_b4[31:0] >> 15;
        pr_b7    = ({8'd0, sd_reg[5].up} - $unsigned(b3_reg)) * b7_scale;
        b7_next  = pr_b7[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[COEF_ST-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= in_side;
            sd_reg[1] <= sd_reg[0];
            sd_reg[2] <= sd2_next;
            for (int i = 3; i < COEF_ST; i++)
                sd_reg[i] <= sd_reg[i-1];
            x2_reg    <= x2_next;
            b5_reg    <= b5_next;
            b6_reg    <= b6_next;
            sq_reg    <= sq_next;
            x2a_reg   <= x2a_next;
            x1c_reg   <= x1c_next;
            x2a_d_reg <= x2a_reg;
            x1c_d_reg <= x1c_reg;
            x1b_reg   <= x1b_next;
            x2c_reg   <= x2c_next;
            b3_reg    <= b3_next;
            u_reg     <= u_next;
            b4_reg    <= b4_next;
            b7_reg    <= b7_next;
        end
    end

    // divider operands: double before dividing while b7 has headroom
    always_comb
    begin
        out_side       = sd_reg[COEF_ST-1];
        out_side.dbl   = b7_reg[31];
        out_side.fault = sd_reg[COEF_ST-1].fault | (b4_reg == 32'd0);
        out_num        = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
        out_den        = b4_reg;
    end

    assign out_valid = v_reg[COEF_ST-1];

endmodule
`default_nettype wire

// ===== rtl/baro_temp_pressure_compensation_top.sv =====
`default_nettype none
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata[15:0] raw_temp, [39:16] raw_press
// m_*       out  tvalid/tready      tdata[15:0] temperature, [47:16] pressure;
//                                   tuser div_fault
// cfg_*     in   cfg_wr_en          cfg_index, cfg_data (no read-back)
//
// one item per cycle sustained while the output is not held; an item passes the
// input registers, the two 32-stage bit-per-stage dividers, the coefficient stages
// and the back end; all stages advance together; a held output stalls the whole pipeline
// rst_n clears valid bits and the calibration registers (oss resets to 3)
module baro_temp_pressure_compensation_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [39:0]                   s_tdata,  // raw_temp, raw_press
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [47:0]                        m_tdata,  // temperature, pressure
    output logic                               m_tuser,  // div_fault
    input  wire logic                          cfg_wr_en,
    input  wire logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bptc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bptc_pkg::*;

    logic [47:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg, cal_d_reg;
    logic [1:0]  oss_reg;
    cal_t        cal;
    logic        en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            cal_d_reg <= '0;
            oss_reg   <= OSS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CAL_AC123: cal_a_reg <= cfg_data;
                REG_CAL_AC456: cal_b_reg <= cfg_data;
                REG_CAL_B12:   cal_c_reg <= cfg_data[31:0];
                REG_CAL_MCMD:  cal_d_reg <= cfg_data[31:0];
                REG_OSS:       oss_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cal.ac1 = $signed(cal_a_reg[47:32]);
        cal.ac2 = $signed(cal_a_reg[31:16]);
        cal.ac3 = $signed(cal_a_reg[15:0]);
        cal.ac4 = cal_b_reg[47:32];
        cal.ac5 = cal_b_reg[31:16];
        cal.ac6 = cal_b_reg[15:0];
        cal.b1  = $signed(cal_c_reg[31:16]);
        cal.b2  = $signed(cal_c_reg[15:0]);
        cal.mc  = $signed(cal_d_reg[31:16]);
        cal.md  = $signed(cal_d_reg[15:0]);
        cal.oss = oss_reg;
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // front: input register and x1
    logic               s1_v_reg, s2_v_reg;
    logic [15:0]        ut_reg;
    logic [23:0]        up_reg, up2_reg;
    logic [23:0]        up_in;
    logic signed [17:0] diff;
    logic signed [34:0] pr_x1;
    logic signed [31:0] x1_next, x1_reg;

    assign up_in = s_tdata[39:16] >> (4'd8 - {2'b00, cal.oss});

    always_comb
    begin
        diff    = $signed({2'b00, ut_reg}) - $signed({2'b00, cal.ac6});
        pr_x1   = diff * $signed({1'b0, cal.ac5});
        x1_next = $signed(pr_x1[31:0]) >>> 15;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_tvalid;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ut_reg  <= s_tdata[15:0];
            up_reg  <= up_in;
            x1_reg  <= x1_next;
            up2_reg <= up_reg;
        end
    end

    // temperature divider operands as magnitudes
    logic [31:0] tnum, tden, tnum_mag, tden_mag, tq, pnum, pden, pq;
    side_t       tside, tside_out, cside, pside_out;
    logic        tdiv_v, cof_v, pdiv_v;

    always_comb
    begin
        tnum        = {{5{cal.mc[15]}}, cal.mc, 11'b0};
        tden        = x1_reg + {{16{cal.md[15]}}, cal.md};
        tnum_mag    = tnum[31] ? ~tnum + 32'd1 : tnum;
        tden_mag    = tden[31] ? ~tden + 32'd1 : tden;
        tside       = '0;
        tside.x1    = x1_reg;
        tside.up    = up2_reg;
        tside.neg   = tnum[31] ^ tden[31];
        tside.fault = (tden == 32'd0);
    end

    bptc_div u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_v_reg),
        .num       (tnum_mag),
        .den       (tden_mag),
        .in_side   (tside),
        .out_valid (tdiv_v),
        .quo       (tq),
        .out_side  (tside_out)
    );

    bptc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cal       (cal),
        .in_valid  (tdiv_v),
        .in_q      (tq),
        .in_side   (tside_out),
        .out_valid (cof_v),
        .out_num   (pnum),
        .out_den   (pden),
        .out_side  (cside)
    );

    bptc_div u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cof_v),
        .num       (pnum),
        .den       (pden),
        .in_side   (cside),
        .out_valid (pdiv_v),
        .quo       (pq),
        .out_side  (pside_out)
    );

    // back: final pressure correction
    logic [3:0]         vq_reg;
    side_t              sq1_reg, sq2_reg, sq3_reg;
    logic signed [31:0] p1_reg, p2_reg, p3_reg, x8_reg, xx_reg, m2_reg, m3_reg;
    logic signed [31:0] y1_reg, pu, x8_next, xx_next, m2_next, y1_next, pf;
    logic signed [63:0] pr_xx;
    logic signed [47:0] pr_m2, pr_y1;
    logic signed [15:0] temp_reg;
    logic signed [31:0] press_reg;
    logic               fault_reg;

    always_comb
    begin
        pu      = pside_out.dbl ? $signed({pq[30:0], 1'b0}) : $signed(pq);
        x8_next = pu >>> 8;
        pr_xx   = x8_reg * x8_reg;
        xx_next = pr_xx[31:0];
        pr_m2   = p1_reg * C_P_K2;
        m2_next = $signed(pr_m2[31:0]) >>> 16;
        pr_y1   = xx_reg * C_P_K1;
        y1_next = $signed(pr_y1[31:0]) >>> 16;
        pf      = p3_reg + ((y1_reg + m3_reg + C_P_K3) >>> 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= '0;
        else if (en)
            vq_reg <= {vq_reg[2:0], pdiv_v};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= pu;
            x8_reg    <= x8_next;
            sq1_reg   <= pside_out;
            p2_reg    <= p1_reg;
            xx_reg    <= xx_next;
            m2_reg    <= m2_next;
            sq2_reg   <= sq1_reg;
            p3_reg    <= p2_reg;
            m3_reg    <= m2_reg;
            y1_reg    <= y1_next;
            sq3_reg   <= sq2_reg;
            temp_reg  <= sq3_reg.fault ? 16'sd0 : sq3_reg.t;
            press_reg <= sq3_reg.fault ? 32'sd0 : pf;
            fault_reg <= sq3_reg.fault;
        end
    end

    assign m_tvalid = vq_reg[3];
    assign m_tdata  = {press_reg, temp_reg};
    assign m_tuser  = fault_reg;

`ifndef ASSERT_OFF
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 48'd0)
        else $error("fault item carries nonzero results");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output held");

    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> s1_v_reg == $past(s1_v_reg) && s2_v_reg == $past(s2_v_reg))
        else $error("front valid bits moved during stall");
`endif

endmodule
`default_nettype wire
